// ----- rtl/core/register_bytecode_interpreter_assert.svh -----
// ----------------------------------------------------------------------------
// register bytecode interpreter assertion macros
// concurrent checks sampled on the rising clock edge, off during reset
// ----------------------------------------------------------------------------
`ifndef REGISTER_BYTECODE_INTERPRETER_ASSERT_SVH
`define REGISTER_BYTECODE_INTERPRETER_ASSERT_SVH

// same-cycle implication
`define RBI_ASSERT_IMP(LABEL, CLK, RSTN, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("rbi assertion failed");

// next-cycle implication
`define RBI_ASSERT_NXT(LABEL, CLK, RSTN, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("rbi assertion failed");

`endif

// ----- rtl/core/rbi_pkg.sv -----
// ----------------------------------------------------------------------------
// rbi_pkg
// shared constants, opcodes and types of the register bytecode interpreter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbi_pkg;

  // register file geometry, count is a power of two
  localparam int REG_COUNT = 256;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int DATA_W    = 32;

  // field widths
  localparam int WORD_W = 32;
  localparam int IDX_W  = 8;

  // instruction queue between decode and execute
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // opcodes
  localparam logic [2:0] OP_LDCONST = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_SUB     = 3'd2;
  localparam logic [2:0] OP_MUL     = 3'd3;
  localparam logic [2:0] OP_SHOW    = 3'd4;
  localparam logic [2:0] OP_HALT    = 3'd5;

  // decode phase codes
  localparam logic [1:0] PH_OP    = 2'd0;
  localparam logic [1:0] PH_DST   = 2'd1;
  localparam logic [1:0] PH_SRC_L = 2'd2;
  localparam logic [1:0] PH_SRC_R = 2'd3;

  typedef enum logic [1:0] {
    K_LOADK,
    K_ALU,
    K_PRINT
  } kind_t;

  // one complete decoded instruction
  typedef struct packed {
    kind_t             kind;
    logic [2:0]        op;
    logic [IDX_W-1:0]  dest;
    logic [IDX_W-1:0]  a_idx;
    logic [IDX_W-1:0]  b_idx;
    logic [DATA_W-1:0] konst;
  } instr_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       halted;
  } front_stat_t;

  typedef struct packed {
    logic stall;
    logic print_go;
  } back_stat_t;

  // register index from the low byte, wraps on the register count
  function automatic logic [REG_IDX_W-1:0] reg_addr(input logic [IDX_W-1:0] idx);
    return REG_IDX_W'(idx);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rbi_ram.sv -----
// ----------------------------------------------------------------------------
// rbi_ram
// generic ram, one write port, two read ports, registered read-first data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rbi_front.sv -----
// ----------------------------------------------------------------------------
// rbi_front
// word decoder, collects operands and pushes whole instructions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbi_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [31:0]         in_word,
  input  wire logic                       in_last_word,
  input  wire logic                       q_full,
  output logic                            push,
  output rbi_pkg::instr_t                 push_instr,
  output rbi_pkg::front_stat_t            stat
);

  logic                       acc;
  logic [1:0]                 phase_r, phase_nxt;
  logic [2:0]                 pend_r, pend_nxt;
  logic                       halted_r, halted_nxt;
  logic [rbi_pkg::IDX_W-1:0]  dest_r, dest_nxt;
  logic [rbi_pkg::IDX_W-1:0]  lidx_r, lidx_nxt;
  logic [rbi_pkg::IDX_W-1:0]  widx;
  logic                       is_op;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign widx     = in_word[rbi_pkg::IDX_W-1:0];
  // opcode word in 0..4
  assign is_op    = (in_word[31:3] == '0) && (in_word[2:0] <= rbi_pkg::OP_SHOW);

  assign stat.phase  = phase_r;
  assign stat.halted = halted_r;

  always_comb begin
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    halted_nxt = halted_r;
    dest_nxt   = dest_r;
    lidx_nxt   = lidx_r;
    push       = 1'b0;
    push_instr = '0;
    push_instr.op    = pend_r;
    push_instr.dest  = dest_r;
    push_instr.a_idx = lidx_r;
    push_instr.b_idx = widx;
    push_instr.konst = rbi_pkg::DATA_W'(in_word);
    if (acc) begin
      if (!halted_r) begin
        unique case (phase_r)
          rbi_pkg::PH_OP: begin
            if (is_op) begin
              pend_nxt  = in_word[2:0];
              phase_nxt = rbi_pkg::PH_DST;
            end else if (in_word == 32'(rbi_pkg::OP_HALT)) begin
              halted_nxt = 1'b1;
            end
          end
          rbi_pkg::PH_DST: begin
            if (pend_r == rbi_pkg::OP_SHOW) begin
              push             = 1'b1;
              push_instr.kind  = rbi_pkg::K_PRINT;
              push_instr.a_idx = widx;
              phase_nxt        = rbi_pkg::PH_OP;
            end else begin
              dest_nxt  = widx;
              phase_nxt = rbi_pkg::PH_SRC_L;
            end
          end
          rbi_pkg::PH_SRC_L: begin
            if (pend_r == rbi_pkg::OP_LDCONST) begin
              push            = 1'b1;
              push_instr.kind = rbi_pkg::K_LOADK;
              phase_nxt       = rbi_pkg::PH_OP;
            end else begin
              lidx_nxt  = widx;
              phase_nxt = rbi_pkg::PH_SRC_R;
            end
          end
          rbi_pkg::PH_SRC_R: begin
            push            = 1'b1;
            push_instr.kind = rbi_pkg::K_ALU;
            phase_nxt       = rbi_pkg::PH_OP;
          end
          default: begin
            phase_nxt = rbi_pkg::PH_OP;
          end
        endcase
      end
      // program end drops partial instruction and leaves halt
      if (in_last_word) begin
        phase_nxt  = rbi_pkg::PH_OP;
        halted_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rbi_pkg::PH_OP;
      pend_r   <= rbi_pkg::OP_LDCONST;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pend_r   <= pend_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dest_r <= dest_nxt;
    lidx_r <= lidx_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/rbi_queue.sv -----
// ----------------------------------------------------------------------------
// rbi_queue
// small instruction fifo between decode and execute
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbi_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire rbi_pkg::instr_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output rbi_pkg::instr_t      head
);

  rbi_pkg::instr_t               mem_r [rbi_pkg::QDEPTH];
  logic [rbi_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [rbi_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [rbi_pkg::QPTR_W:0]      count_r, count_nxt;

  assign full  = (count_r == (rbi_pkg::QPTR_W + 1)'(rbi_pkg::QDEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rbi_back.sv -----
// ----------------------------------------------------------------------------
// rbi_back
// execute pipeline: register read, alu and write back, print output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbi_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire rbi_pkg::instr_t     q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_printed_register,
  output logic signed [31:0]       out_printed_value,
  output rbi_pkg::back_stat_t      stat
);

  localparam int AW = rbi_pkg::REG_IDX_W;
  localparam int DW = rbi_pkg::DATA_W;

  logic                       s2_v_r;
  rbi_pkg::instr_t            s2_ins_r;
  logic                       rv0_r, rv1_r;
  logic                       wb_v_r;
  logic [AW-1:0]              wb_addr_r;
  logic [DW-1:0]              wb_data_r;
  logic [rbi_pkg::REG_COUNT-1:0] vld_r;
  logic                       out_v_r;
  logic [7:0]                 out_reg_r;
  logic [31:0]                out_val_r;

  logic                       s2_print, stall, s2_go, issue, we;
  logic [AW-1:0]              ra0, ra1, a_addr, b_addr, waddr;
  logic [DW-1:0]              rd0, rd1, opa, opb, res;

  assign s2_print = s2_v_r && (s2_ins_r.kind == rbi_pkg::K_PRINT);
  assign stall    = s2_print && out_v_r && !out_ready;
  assign s2_go    = s2_v_r && !stall;
  assign issue    = q_valid && !stall;
  assign q_pop    = issue;

  assign ra0    = rbi_pkg::reg_addr(q_head.a_idx);
  assign ra1    = rbi_pkg::reg_addr(q_head.b_idx);
  assign a_addr = rbi_pkg::reg_addr(s2_ins_r.a_idx);
  assign b_addr = rbi_pkg::reg_addr(s2_ins_r.b_idx);
  assign waddr  = rbi_pkg::reg_addr(s2_ins_r.dest);

  rbi_ram #(
    .WIDTH (DW),
    .DEPTH (rbi_pkg::REG_COUNT)
  ) u_regfile (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (res),
    .re     (issue),
    .raddr0 (ra0),
    .raddr1 (ra1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  // bypass the write that landed on the read edge, unwritten entries read zero
  assign opa = (wb_v_r && (wb_addr_r == a_addr)) ? wb_data_r : (rv0_r ? rd0 : '0);
  assign opb = (wb_v_r && (wb_addr_r == b_addr)) ? wb_data_r : (rv1_r ? rd1 : '0);

  always_comb begin
    res = '0;
    unique case (s2_ins_r.kind)
      rbi_pkg::K_LOADK: res = s2_ins_r.konst;
      rbi_pkg::K_ALU: begin
        unique case (s2_ins_r.op)
          rbi_pkg::OP_ADD: res = opa + opb;
          rbi_pkg::OP_SUB: res = opa - opb;
          rbi_pkg::OP_MUL: res = opa * opb;
          default:         res = '0;
        endcase
      end
      default: res = '0;
    endcase
  end

  assign we = s2_go && ((s2_ins_r.kind == rbi_pkg::K_LOADK) ||
                        (s2_ins_r.kind == rbi_pkg::K_ALU));

  assign out_valid            = out_v_r;
  assign out_printed_register = out_reg_r;
  assign out_printed_value    = out_val_r;

  assign stat.stall    = stall;
  assign stat.print_go = s2_print && s2_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      wb_v_r  <= 1'b0;
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (!stall) begin
        s2_v_r <= issue;
        wb_v_r <= we;
      end
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (s2_print && s2_go) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_ins_r <= q_head;
      rv0_r    <= vld_r[ra0];
      rv1_r    <= vld_r[ra1];
    end
    if (!stall) begin
      wb_addr_r <= waddr;
      wb_data_r <= res;
    end
    if (s2_print && s2_go) begin
      out_reg_r <= s2_ins_r.a_idx;
      out_val_r <= 32'($signed(opa));
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/register_bytecode_interpreter.sv -----
// ----------------------------------------------------------------------------
// register_bytecode_interpreter
// streaming bytecode interpreter over a 256 x 32 register file
// ----------------------------------------------------------------------------
// The block takes one bytecode word per transfer and accepts a word in every
// cycle while the four-entry instruction queue has room. The decoder collects
// the words of LOADK, ADD, SUB, MUL and PRINT into whole instructions and
// pushes them into the queue; HALT and unknown opcode words push nothing.
// The execute side takes one instruction per cycle unless stalled, first a
// register file read (two read ports, registered), then compute and write
// back, with a bypass so back-to-back dependent instructions see fresh values.
// A PRINT result passes from the queue through the register read stage into
// the output register; execution stalls only while a printed value waits
// to be taken and another PRINT is ready, and the queue then fills and drops
// in_ready. Registers read as zero after reset through per-entry valid bits,
// so there is no clearing pass. A word with in_last_word set ends the program
// and clears any partial instruction and the halt state; register contents
// persist across programs.
`timescale 1ns / 1ps
`default_nettype none
`include "register_bytecode_interpreter_assert.svh"

module register_bytecode_interpreter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input words
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_word,
  input  wire logic               in_last_word,
  // print results
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_printed_register,
  output logic signed [31:0]      out_printed_value
);

  // decode to queue
  logic                  q_push;
  rbi_pkg::instr_t       q_push_instr;
  logic                  q_full;
  // queue to execute
  logic                  q_pop;
  logic                  q_valid;
  rbi_pkg::instr_t       q_head;
  // status for checks
  rbi_pkg::front_stat_t  fr_stat;
  rbi_pkg::back_stat_t   bk_stat;
  logic                  in_last_xfer;
  logic                  fr_idle;

  // front: accepts every transfer while the queue has room
  rbi_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .in_last_word (in_last_word),
    .q_full       (q_full),
    .push         (q_push),
    .push_instr   (q_push_instr),
    .stat         (fr_stat)
  );

  // decouples decode from execute stalls
  rbi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_instr),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // back: register read, execute, write back and print output register
  rbi_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_printed_register (out_printed_register),
    .out_printed_value    (out_printed_value),
    .stat                 (bk_stat)
  );

  // last word of a program taken, decoder back at opcode phase and running
  assign in_last_xfer = in_valid && in_ready && in_last_word;
  assign fr_idle      = (fr_stat.phase == rbi_pkg::PH_OP) && !fr_stat.halted;

  // never pop an empty queue
  `RBI_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, q_valid)
  // no register read issued while stage two holds a stalled print
  `RBI_ASSERT_IMP(a_no_issue_on_stall, clk, rst_n, bk_stat.stall, !q_pop)
  // a print leaving stage two shows up on the output
  `RBI_ASSERT_NXT(a_print_shows, clk, rst_n, bk_stat.print_go, out_valid)
  // program end returns decode to opcode phase, running
  `RBI_ASSERT_NXT(a_last_clears, clk, rst_n, in_last_xfer, fr_idle)

endmodule

`default_nettype wire
